// ----- rtl/blpd_pkg.sv -----
// ----------------------------------------------------------------------------
// blpd_pkg: shared types and constants for the bounded linked list
// command, status and payload definitions used by controller and datapath
// ----------------------------------------------------------------------------
package blpd_pkg;

  localparam int Capacity  = 32;
  localparam int SlotW     = $clog2(Capacity);
  localparam int CountW    = $clog2(Capacity + 1);
  localparam int DataW     = 32;
  localparam int ElemW     = 32;
  localparam int OpW       = 3;
  localparam int PosW      = 7;
  localparam int StatusW   = 2;
  localparam int OutCountW = 7;

  localparam logic [OpW-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [OpW-1:0] OP_DEL_BACK  = 3'd3;
  localparam logic [OpW-1:0] OP_DEL_POS   = 3'd4;
  localparam logic [OpW-1:0] OP_DUMP      = 3'd5;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY   = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd2;
  localparam logic [StatusW-1:0] ST_INVALID = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item
    logic walk_rst; // cursor to head (tail for delete back), walk index 1
    logic walk;     // cursor follows next link
    logic insert;   // link new node (front or back from held opcode)
    logic unlink;   // unlink cursor node
    logic rd;       // read cursor node links and value
  } blpd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OpW-1:0]    op;
    logic              empty;
    logic              full;
    logic              pos_ok;
    logic              walk_done; // walk index reached target
  } blpd_stat_t;

endpackage

// ----- rtl/blpd_datapath.sv -----
// ----------------------------------------------------------------------------
// blpd_datapath: node pool, links, head/tail/count and walk cursor
// memories for value and links, one read port each with registered data
// ----------------------------------------------------------------------------
module blpd_datapath
  import blpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  blpd_cmd_t           cmd,
  input  logic [OpW-1:0]      opcode,
  input  logic [DataW-1:0]    value,
  input  logic [PosW-1:0]     position,
  output blpd_stat_t          stat,
  output logic [CountW-1:0]   cnt,
  output logic [ElemW-1:0]    rd_value
);

  logic [DataW-1:0] value_mem [Capacity];
  logic [SlotW-1:0] next_mem  [Capacity];
  logic [SlotW-1:0] prev_mem  [Capacity];
  logic [Capacity-1:0] slot_used;
  logic [SlotW-1:0] head_slot, tail_slot;
  logic [CountW-1:0] list_count;

  logic [OpW-1:0]   op;
  logic [DataW-1:0] val;
  logic [PosW-1:0]  pos;
  logic [SlotW-1:0] cur;
  logic [PosW-1:0]  idx;
  logic [SlotW-1:0] rd_next, rd_prev;

  // lowest free slot
  logic [SlotW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (!slot_used[i]) free_slot = SlotW'(i);
    end
  end

  assign stat.op        = op;
  assign stat.empty     = (list_count == '0);
  assign stat.full      = (list_count == CountW'(Capacity));
  assign stat.pos_ok    = (pos != '0) && ({1'b0, pos} <= (PosW + 1)'(list_count));
  assign stat.walk_done = (idx == pos);
  assign cnt            = list_count;

  // node reads, cursor address
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_next  <= next_mem[cur];
      rd_prev  <= prev_mem[cur];
      rd_value <= ElemW'(value_mem[cur]);
    end
  end

  // link writes; at most one of insert or unlink per cycle, a few writes each
  logic [SlotW-1:0] s, n_u, p_u;
  assign s   = free_slot;
  assign n_u = rd_next;
  assign p_u = rd_prev;

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      value_mem[s] <= val;
      if (list_count == '0) begin
        next_mem[s] <= s;
        prev_mem[s] <= s;
      end else begin
        next_mem[s]         <= head_slot;
        prev_mem[s]         <= tail_slot;
        next_mem[tail_slot] <= s;
        prev_mem[head_slot] <= s;
      end
    end else if (cmd.unlink && list_count > CountW'(1)) begin
      next_mem[p_u] <= n_u;
      prev_mem[n_u] <= p_u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used  <= '0;
      head_slot  <= '0;
      tail_slot  <= '0;
      list_count <= '0;
    end else if (cmd.insert) begin
      slot_used[s] <= 1'b1;
      list_count   <= list_count + 1'b1;
      if (list_count == '0) begin
        head_slot <= s;
        tail_slot <= s;
      end else if (op == OP_INS_FRONT) begin
        head_slot <= s;
      end else begin
        tail_slot <= s;
      end
    end else if (cmd.unlink) begin
      slot_used[cur] <= 1'b0;
      if (list_count <= CountW'(1)) begin
        list_count <= '0;
        head_slot  <= '0;
        tail_slot  <= '0;
      end else begin
        list_count <= list_count - 1'b1;
        if (cur == head_slot) head_slot <= n_u;
        if (cur == tail_slot) tail_slot <= p_u;
      end
    end
  end

  // input capture and walk cursor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= opcode;
      val <= value;
      pos <= position;
    end
    if (cmd.walk_rst) begin
      cur <= (op == OP_DEL_BACK) ? tail_slot : head_slot;
      idx <= PosW'(1);
    end else if (cmd.walk) begin
      cur <= rd_next;
      idx <= idx + 1'b1;
    end
  end

endmodule

// ----- rtl/blpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// blpd_ctrl: sequencer for list commands
// decodes the held opcode, steps the walk and drives the result strobe
// ----------------------------------------------------------------------------
module blpd_ctrl
  import blpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  blpd_stat_t        stat,
  input  logic [CountW-1:0] cnt,
  input  logic [ElemW-1:0]  rd_value,
  output blpd_cmd_t         cmd,
  output logic              busy,
  output logic              done,
  output logic [StatusW-1:0] status,
  output logic [OutCountW-1:0] entry_count,
  output logic [ElemW-1:0]  element,
  output logic              last
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_READ, S_STEP, S_UNLINK, S_DUMP, S_REPORT
  } state_t;

  state_t state;
  logic [StatusW-1:0] st_hold;
  logic [CountW-1:0]  dump_left;

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && start;
    unique case (state)
      S_DECODE: begin
        cmd.walk_rst = 1'b1;
        cmd.insert = (stat.op == OP_INS_FRONT || stat.op == OP_INS_BACK) && !stat.full;
      end
      S_READ:   cmd.rd = 1'b1;
      S_STEP:   cmd.walk = 1'b1;
      S_UNLINK: cmd.unlink = 1'b1;
      S_DUMP:   cmd.walk = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      status    <= ST_OK;
      entry_count <= '0;
      element   <= '0;
      last      <= 1'b0;
      st_hold   <= ST_OK;
      dump_left <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) state <= S_DECODE;
        S_DECODE: begin
          st_hold <= ST_OK;
          state   <= S_REPORT;
          case (stat.op)
            OP_INS_FRONT, OP_INS_BACK: if (stat.full) st_hold <= ST_FULL;
            OP_DEL_FRONT, OP_DEL_BACK: begin
              if (stat.empty) st_hold <= ST_EMPTY;
              else state <= S_READ;
            end
            OP_DEL_POS: begin
              if (!stat.pos_ok) st_hold <= ST_INVALID;
              else state <= S_READ;
            end
            OP_DUMP: begin
              if (stat.empty) st_hold <= ST_EMPTY;
              else begin
                dump_left <= cnt;
                state     <= S_READ;
              end
            end
            default: st_hold <= ST_INVALID;
          endcase
        end
        S_READ: begin
          if (stat.op == OP_DUMP) state <= S_DUMP;
          else if (stat.op == OP_DEL_POS && !stat.walk_done) state <= S_STEP;
          else state <= S_UNLINK;
        end
        S_STEP: state <= S_READ;
        S_UNLINK: state <= S_REPORT;
        S_DUMP: begin
          done        <= 1'b1;
          status      <= ST_OK;
          entry_count <= OutCountW'(cnt);
          element     <= rd_value;
          last        <= (dump_left == CountW'(1));
          dump_left   <= dump_left - 1'b1;
          state       <= (dump_left == CountW'(1)) ? S_IDLE : S_READ;
        end
        S_REPORT: begin
          done        <= 1'b1;
          status      <= st_hold;
          entry_count <= OutCountW'(cnt);
          element     <= '0;
          last        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/bounded_list_positional_delete.sv -----
// ----------------------------------------------------------------------------
// bounded_list_positional_delete: bounded circular doubly linked list
// ordered list of signed words in a 32-node pool with insert, delete and dump
// ----------------------------------------------------------------------------
// a transaction is accepted on a clock edge with start high and busy low.
// results appear for one cycle each with done high and cannot be stalled:
// the receiver must take every result in the cycle it is shown. inserts pass
// through decode and report, deletes through decode, read, unlink and report
// (at position k first alternating read and step until the walk reaches k),
// and a dump alternates read and dump; the walk follows one next link per
// step via the link memory's single read port. dump gives one result per
// element, head to tail, last on the final one; others give one result with
// status and new count. busy falls in the cycle the last result is shown.
// ----------------------------------------------------------------------------
module bounded_list_positional_delete
  import blpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [OpW-1:0]            opcode,
  input  logic signed [DataW-1:0]   value,
  input  logic [PosW-1:0]           position,
  output logic                      done,
  output logic [StatusW-1:0]        status,
  output logic [OutCountW-1:0]      entry_count,
  output logic signed [ElemW-1:0]   element,
  output logic                      last
);

  blpd_cmd_t          cmd;
  blpd_stat_t         stat;
  logic [CountW-1:0]  cnt;
  logic [ElemW-1:0]   rd_value;

  // node pool and list pointers
  blpd_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .opcode   (opcode),
    .value    (value),
    .position (position),
    .stat     (stat),
    .cnt      (cnt),
    .rd_value (rd_value)
  );

  // command sequencer and result register
  blpd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .stat        (stat),
    .cnt         (cnt),
    .rd_value    (rd_value),
    .cmd         (cmd),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .entry_count (entry_count),
    .element     (element),
    .last        (last)
  );

endmodule
